// ===== design/c2d_pkg.sv =====
`default_nettype none
package c2d_pkg;
  localparam int VALUE_BITS = 16;

  localparam logic [1:0] FUNC_WEIGHT  = 2'd0;
  localparam logic [1:0] FUNC_BIAS    = 2'd1;
  localparam logic [1:0] FUNC_INPUT   = 2'd2;
  localparam logic [1:0] FUNC_COMPUTE = 2'd3;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  localparam logic [2:0] REG_IN_ROWS   = 3'd0;
  localparam logic [2:0] REG_IN_COLS   = 3'd1;
  localparam logic [2:0] REG_IN_CHANS  = 3'd2;
  localparam logic [2:0] REG_KERN_ROWS = 3'd3;
  localparam logic [2:0] REG_KERN_COLS = 3'd4;
  localparam logic [2:0] REG_OUT_CHANS = 3'd5;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  out_chan;
    logic [1:0]  in_chan;
    logic [4:0]  row;
    logic [4:0]  col;
    logic [15:0] value;
  } item_t;
endpackage
`default_nettype wire

// ===== design/c2d_queue.sv =====
`default_nettype none
module c2d_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         rd,
  output logic [W-1:0]      rdata,
  output logic              empty
);
  logic [W-1:0] mem [2];
  logic         wp, rp;
  logic [1:0]   cnt;

  assign full  = cnt == 2'd2;
  assign empty = cnt == 2'd0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

// ===== design/c2d_engine.sv =====
`default_nettype none
module c2d_engine #(
  parameter int MAX_DIM    = 32,
  parameter int MAX_IN_CH  = 4,
  parameter int MAX_OUT_CH = 4,
  parameter int MAX_KERN   = 5
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire c2d_pkg::item_t q_item,
  input  wire logic           q_empty,
  output logic                q_rd,
  input  wire logic [5:0]     in_rows,
  input  wire logic [5:0]     in_cols,
  input  wire logic [2:0]     in_chans,
  input  wire logic [2:0]     kern_rows,
  input  wire logic [2:0]     kern_cols,
  input  wire logic [2:0]     out_chans,
  output logic                result_valid,
  input  wire logic           result_stall,
  output logic [15:0]         result_value,
  output logic [1:0]          status,
  output logic                busy
);
  import c2d_pkg::*;

  localparam int IMG_D = MAX_IN_CH * MAX_DIM * MAX_DIM;
  localparam int WGT_D = MAX_OUT_CH * MAX_IN_CH * MAX_KERN * MAX_KERN;
  localparam int IAW   = $clog2(IMG_D);
  localparam int WAW   = $clog2(WGT_D);
  localparam int BAW   = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
  localparam int ACCW  = 2 * VALUE_BITS + 16;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_RUN = 5'b00010, S_DRAIN = 5'b00100,
    S_FIN = 5'b01000, S_OUT = 5'b10000
  } state_t;

  state_t state;

  logic signed [VALUE_BITS-1:0] img [IMG_D];
  logic signed [VALUE_BITS-1:0] wgt [WGT_D];
  logic signed [VALUE_BITS-1:0] bias [MAX_OUT_CH];

  function automatic logic [6:0] eff(input logic [5:0] v, input int mx);
    if (v == 6'd0) return 7'd1;
    if ({1'b0, v} > 7'(mx)) return 7'(mx);
    return {1'b0, v};
  endfunction

  logic [6:0] ir, icl, ich, kr, kc, och;
  assign ir  = eff(in_rows, MAX_DIM);
  assign icl = eff(in_cols, MAX_DIM);
  assign ich = eff({3'd0, in_chans}, MAX_IN_CH);
  assign kr  = eff({3'd0, kern_rows}, MAX_KERN);
  assign kc  = eff({3'd0, kern_cols}, MAX_KERN);
  assign och = eff({3'd0, out_chans}, MAX_OUT_CH);

  logic [1:0] oc_r;
  logic [4:0] r_r, c_r;
  logic [6:0] ch, ki, kj;
  logic       last;
  logic       p_valid, p_last;
  logic signed [VALUE_BITS-1:0] x_q, w_q;
  logic signed [2*VALUE_BITS-1:0] prod;
  logic       m_valid, m_last;
  logic signed [ACCW-1:0] acc;

  logic bad;
  assign bad = (kr > ir) || (kc > icl) || ({5'd0, q_item.out_chan} >= och) ||
               ({2'd0, q_item.row} >= ir - kr + 7'd1) ||
               ({2'd0, q_item.col} >= icl - kc + 7'd1);

  assign busy  = state != S_IDLE;
  assign q_rd  = (state == S_IDLE) && !q_empty;
  assign last  = (ki == kr - 7'd1) && (kj == kc - 7'd1) && (ch == ich - 7'd1);

  logic [IAW-1:0] xa;
  logic [WAW-1:0] wa;
  always_comb begin
    xa = IAW'((32'(ch) * MAX_DIM + 32'(r_r) + 32'(ki)) * MAX_DIM + 32'(c_r) + 32'(kj));
    wa = WAW'(((32'(oc_r) * MAX_IN_CH + 32'(ch)) * MAX_KERN + 32'(ki)) * MAX_KERN + 32'(kj));
  end

  logic signed [ACCW-1:0] q_s;
  assign q_s = acc >>> 8;

  always_ff @(posedge clk) begin
    // load writes
    if (q_rd) begin
      case (q_item.func)
        FUNC_WEIGHT:
          if (32'(q_item.out_chan) < MAX_OUT_CH && 32'(q_item.in_chan) < MAX_IN_CH &&
              32'(q_item.row) < MAX_KERN && 32'(q_item.col) < MAX_KERN)
            wgt[WAW'(((32'(q_item.out_chan) * MAX_IN_CH + 32'(q_item.in_chan)) * MAX_KERN
                + 32'(q_item.row)) * MAX_KERN + 32'(q_item.col))] <=
              VALUE_BITS'($signed(q_item.value));
        FUNC_BIAS:
          if (32'(q_item.out_chan) < MAX_OUT_CH)
            bias[BAW'(q_item.out_chan)] <= VALUE_BITS'($signed(q_item.value));
        FUNC_INPUT:
          if (32'(q_item.in_chan) < MAX_IN_CH && 32'(q_item.row) < MAX_DIM &&
              32'(q_item.col) < MAX_DIM)
            img[IAW'((32'(q_item.in_chan) * MAX_DIM + 32'(q_item.row)) * MAX_DIM
                + 32'(q_item.col))] <= VALUE_BITS'($signed(q_item.value));
        default: ;
      endcase
    end
    x_q <= img[xa];
    w_q <= wgt[wa];
    prod <= x_q * w_q;
    if (rst) begin
      state <= S_IDLE;
      result_valid <= 1'b0;
      p_valid <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      p_valid <= state == S_RUN;
      m_valid <= p_valid;
      m_last <= p_last;
      if (m_valid) acc <= acc + ACCW'(prod);
      case (state)
        S_IDLE:
          if (q_rd && q_item.func == FUNC_COMPUTE) begin
            oc_r <= q_item.out_chan;
            r_r <= q_item.row;
            c_r <= q_item.col;
            ch <= 7'd0; ki <= 7'd0; kj <= 7'd0;
            acc <= ACCW'(bias[BAW'(q_item.out_chan)]) <<< 8;
            if (bad) begin
              result_value <= 16'd0;
              status <= ST_BAD;
              result_valid <= 1'b1;
              state <= S_OUT;
            end else state <= S_RUN;
          end
        S_RUN: begin
          p_last <= last;
          if (last) state <= S_DRAIN;
          else if (kj == kc - 7'd1) begin
            kj <= 7'd0;
            if (ki == kr - 7'd1) begin ki <= 7'd0; ch <= ch + 7'd1; end
            else ki <= ki + 7'd1;
          end else kj <= kj + 7'd1;
        end
        S_DRAIN: if (m_valid && m_last) state <= S_FIN;
        S_FIN: begin
          if (q_s > ACCW'((64'sd1 <<< (VALUE_BITS - 1)) - 1)) begin
            result_value <= 16'((64'sd1 <<< (VALUE_BITS - 1)) - 1);
            status <= ST_SAT;
          end else if (q_s < -(ACCW'(64'sd1 <<< (VALUE_BITS - 1)))) begin
            result_value <= 16'(-(64'sd1 <<< (VALUE_BITS - 1)));
            status <= ST_SAT;
          end else begin
            result_value <= 16'(q_s);
            status <= ST_OK;
          end
          result_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT:
          if (!result_stall) begin
            result_valid <= 1'b0;
            state <= S_IDLE;
          end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/conv2d_multichannel.sv =====
`default_nettype none
// Channel | Dir | Handshake     | Payload
// in      | in  | valid / stall | func out_chan in_chan row col value
// result  | out | valid / stall | result_value status
// cfg     | in  | valid / ready | cfg_index cfg_data
// Loads are written into their stores as they leave the queue. A compute item uses the
// single shared MAC for each of the in_chans*kern_rows*kern_cols products in turn; the
// next item leaves the queue only after its result is taken, so result stall holds it.
// rst is synchronous; stores are undefined until written.
// A two-beat queue parts the input side from the engine, so input stalls only when full.
module conv2d_multichannel #(
  parameter int MAX_DIM    = 32,
  parameter int MAX_IN_CH  = 4,
  parameter int MAX_OUT_CH = 4,
  parameter int MAX_KERN   = 5
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  func,
  input  wire logic [1:0]  out_chan,
  input  wire logic [1:0]  in_chan,
  input  wire logic [4:0]  row,
  input  wire logic [4:0]  col,
  input  wire logic [15:0] value,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [15:0]      result_value,
  output logic [1:0]       status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [5:0]  cfg_data
);
  import c2d_pkg::*;

  logic [5:0] in_rows, in_cols;
  logic [2:0] in_chans, kern_rows, kern_cols, out_chans;
  item_t in_item, q_item;
  logic  q_full, q_empty, q_rd, busy;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign in_item   = '{func, out_chan, in_chan, row, col, value};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_rows <= 6'd28; in_cols <= 6'd28; in_chans <= 3'd1;
      kern_rows <= 3'd3; kern_cols <= 3'd3; out_chans <= 3'd2;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IN_ROWS:   in_rows <= cfg_data;
        REG_IN_COLS:   in_cols <= cfg_data;
        REG_IN_CHANS:  in_chans <= cfg_data[2:0];
        REG_KERN_ROWS: kern_rows <= cfg_data[2:0];
        REG_KERN_COLS: kern_cols <= cfg_data[2:0];
        REG_OUT_CHANS: out_chans <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  c2d_queue #(.W($bits(item_t))) u_queue (
    .clk, .rst, .wr(in_valid && !q_full), .wdata(in_item), .full(q_full),
    .rd(q_rd), .rdata(q_item), .empty(q_empty)
  );

  c2d_engine #(
    .MAX_DIM(MAX_DIM), .MAX_IN_CH(MAX_IN_CH), .MAX_OUT_CH(MAX_OUT_CH),
    .MAX_KERN(MAX_KERN)
  ) u_engine (
    .clk, .rst, .q_item, .q_empty, .q_rd,
    .in_rows, .in_cols, .in_chans, .kern_rows, .kern_cols, .out_chans,
    .result_valid, .result_stall, .result_value, .status, .busy
  );

  a_status: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> status != 2'd3) else $error("bad status");
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_BAD |-> result_value == 16'd0) else $error("bad not zero");
  a_idle_out: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !result_valid) else $error("result while idle");
endmodule
`default_nettype wire

// ===== dv/conv2d_multichannel_test.sv =====
`timescale 1ns / 100ps
module conv2d_multichannel_test;
  import c2d_pkg::*;

  localparam int NUM_ITEMS = 1950;
  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 200;
  localparam int NUM_PHASES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] func = '0, out_chan = '0, in_chan = '0;
  logic [4:0] row = '0, col = '0;
  logic [15:0] value = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [15:0] result_value;
  logic [1:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [5:0] cfg_data = '0;

  conv2d_multichannel u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .out_chan(out_chan), .in_chan(in_chan),
    .row(row), .col(col), .value(value),
    .result_valid(result_valid), .result_stall(result_stall),
    .result_value(result_value), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // shadow of the block: stores, written marks, dimension registers
  logic signed [15:0] fmap [4][32][32];
  logic signed [15:0] kern [4][4][5][5];
  logic signed [15:0] bias [4];
  bit fmap_wr [4][32][32];
  bit kern_wr [4][4][5][5];
  bit bias_wr [4];
  logic [5:0] dim_reg [6];

  logic [15:0] pend_value [$];
  logic [1:0] pend_status [$];

  int errors = 0;
  int in_beats = 0, out_beats = 0, cfg_beats = 0;
  int idle_phase = 0;
  int send_pct = 0, stall_pct = 0;

  typedef struct {
    item_t it;
    bit typed;
    logic [15:0] tv;
    logic [1:0] ts;
  } dir_row_t;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int eff_dim(input int v, input int maxv);
    if (v == 0) return 1;
    return v > maxv ? maxv : v;
  endfunction

  function automatic int in_rows_e();   return eff_dim(dim_reg[REG_IN_ROWS], 32);  endfunction
  function automatic int in_cols_e();   return eff_dim(dim_reg[REG_IN_COLS], 32);  endfunction
  function automatic int in_chans_e();  return eff_dim(dim_reg[REG_IN_CHANS], 4);  endfunction
  function automatic int kern_rows_e(); return eff_dim(dim_reg[REG_KERN_ROWS], 5); endfunction
  function automatic int kern_cols_e(); return eff_dim(dim_reg[REG_KERN_COLS], 5); endfunction
  function automatic int out_chans_e(); return eff_dim(dim_reg[REG_OUT_CHANS], 4); endfunction

  function automatic bit coord_ok(input int oc, input int r, input int c);
    int ir, icl, kr, kc;
    ir = in_rows_e(); icl = in_cols_e(); kr = kern_rows_e(); kc = kern_cols_e();
    return !(kr > ir || kc > icl || oc >= out_chans_e() ||
             r >= ir - kr + 1 || c >= icl - kc + 1);
  endfunction

  // one output element: biased exact sum, floored by 8 bits, saturated
  task automatic predict_output(input item_t it, output logic [15:0] pv,
                                output logic [1:0] ps);
    longint acc, q;
    int oc, r, c;
    oc = it.out_chan; r = it.row; c = it.col;
    if (!coord_ok(oc, r, c)) begin
      pv = '0; ps = ST_BAD;
      return;
    end
    acc = longint'(bias[oc]) * 256;
    for (int ch = 0; ch < in_chans_e(); ch++)
      for (int i = 0; i < kern_rows_e(); i++)
        for (int j = 0; j < kern_cols_e(); j++)
          acc += longint'(fmap[ch][r+i][c+j]) * longint'(kern[oc][ch][i][j]);
    q = acc >>> 8;
    ps = ST_OK;
    if (q > 32767) begin
      q = 32767; ps = ST_SAT;
    end else if (q < -32768) begin
      q = -32768; ps = ST_SAT;
    end
    pv = q[15:0];
  endtask

  task automatic apply_item(input item_t it, input bit typed, input logic [15:0] tv,
                            input logic [1:0] ts);
    logic [15:0] pv;
    logic [1:0] ps;
    case (it.func)
      FUNC_WEIGHT: begin
        if (it.row < 5 && it.col < 5) begin
          kern[it.out_chan][it.in_chan][it.row][it.col] = it.value;
          kern_wr[it.out_chan][it.in_chan][it.row][it.col] = 1'b1;
        end
      end
      FUNC_BIAS: begin
        bias[it.out_chan] = it.value;
        bias_wr[it.out_chan] = 1'b1;
      end
      FUNC_INPUT: begin
        fmap[it.in_chan][it.row][it.col] = it.value;
        fmap_wr[it.in_chan][it.row][it.col] = 1'b1;
      end
      default: begin
        predict_output(it, pv, ps);
        if (typed) begin
          pv = tv; ps = ts;
        end
        pend_value.push_back(pv);
        pend_status.push_back(ps);
      end
    endcase
  endtask

  task automatic send_item(input item_t it, input bit typed = 1'b0,
                           input logic [15:0] tv = '0, input logic [1:0] ts = '0);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= it.func; out_chan <= it.out_chan; in_chan <= it.in_chan;
    row <= it.row; col <= it.col; value <= it.value;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    in_beats++;
    apply_item(it, typed, tv, ts);
  endtask

  function automatic logic [15:0] rand_value();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return 16'h7fff;
    if (pick < 15) return 16'h8000;
    if (pick < 60) return 16'($signed($urandom_range(0, 1023)) - 512);
    return 16'($urandom);
  endfunction

  function automatic item_t mk(input logic [1:0] f, input int oc, input int ic,
                               input int r, input int c, input logic [15:0] v);
    item_t it;
    it.func = f; it.out_chan = 2'(oc); it.in_chan = 2'(ic);
    it.row = 5'(r); it.col = 5'(c); it.value = v;
    return it;
  endfunction

  // load whatever the output element reads that was never written
  task automatic fill_for(input int oc, input int r, input int c);
    for (int ch = 0; ch < in_chans_e(); ch++)
      for (int i = 0; i < kern_rows_e(); i++)
        for (int j = 0; j < kern_cols_e(); j++) begin
          if (!fmap_wr[ch][r+i][c+j])
            send_item(mk(FUNC_INPUT, $urandom_range(0, 3), ch, r + i, c + j, rand_value()));
          if (!kern_wr[oc][ch][i][j])
            send_item(mk(FUNC_WEIGHT, oc, ch, i, j, rand_value()));
        end
    if (!bias_wr[oc])
      send_item(mk(FUNC_BIAS, oc, $urandom_range(0, 3), $urandom_range(0, 31),
                   $urandom_range(0, 31), rand_value()));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pend_value.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [5:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_beats++;
    if (idx <= REG_IN_COLS) dim_reg[idx] = data;
    else if (idx <= REG_OUT_CHANS) dim_reg[idx] = data & 6'd7;
    @(posedge clk);
  endtask

  task automatic set_dims(input int ir, input int icl, input int ich, input int kr,
                          input int kc, input int och);
    write_reg(REG_IN_ROWS, 6'(ir));
    write_reg(REG_IN_COLS, 6'(icl));
    write_reg(REG_IN_CHANS, 6'(ich));
    write_reg(REG_KERN_ROWS, 6'(kr));
    write_reg(REG_KERN_COLS, 6'(kc));
    write_reg(REG_OUT_CHANS, 6'(och));
  endtask

  task automatic random_step();
    int pick, oc, r, c;
    item_t it;
    pick = $urandom_range(0, 99);
    if (pick < 60 && coord_ok(0, 0, 0)) begin
      oc = $urandom_range(0, out_chans_e() - 1);
      r = $urandom_range(0, in_rows_e() - kern_rows_e());
      c = $urandom_range(0, in_cols_e() - kern_cols_e());
      fill_for(oc, r, c);
      send_item(mk(FUNC_COMPUTE, oc, $urandom_range(0, 3), r, c, 16'($urandom)));
    end else if (pick < 72) begin
      it = mk(FUNC_COMPUTE, $urandom_range(0, 3), $urandom_range(0, 3),
              $urandom_range(0, 31), $urandom_range(0, 31), 16'($urandom));
      if (coord_ok(it.out_chan, it.row, it.col)) fill_for(it.out_chan, it.row, it.col);
      send_item(it);
    end else begin
      send_item(mk(2'($urandom_range(0, 2)), $urandom_range(0, 3), $urandom_range(0, 3),
                   $urandom_range(0, 31), $urandom_range(0, 31), rand_value()));
    end
  endtask

  // receiver side: random stall, one long hold-off once twenty results have been taken
  int hold_left = 0;
  bit held = 1'b0;
  always @(posedge clk) begin
    if (!held && out_beats == 20) begin
      held <= 1'b1;
      hold_left <= 400;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      out_beats <= out_beats + 1;
      if (pend_value.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%h status=%0d",
                                  result_value, status));
      end else begin
        if (result_value !== pend_value[0])
          report_mismatch($sformatf("result_value %h, want %h", result_value, pend_value[0]));
        if (status !== pend_status[0])
          report_mismatch($sformatf("status %0d, want %0d", status, pend_status[0]));
        void'(pend_value.pop_front());
        void'(pend_status.pop_front());
      end
    end
  end

  int quiet_cycles = 0;
  int last_beats = 0;
  always @(posedge clk) begin
    if (in_beats + out_beats + cfg_beats != last_beats) begin
      last_beats <= in_beats + out_beats + cfg_beats;
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  dir_row_t dir_tab [$];
  int phase_dims [NUM_PHASES][6] = '{
    '{6, 7, 2, 3, 2, 3}, '{32, 32, 4, 5, 5, 4}, '{1, 1, 1, 1, 1, 1}, '{0, 0, 0, 0, 0, 0},
    '{63, 63, 7, 7, 7, 7}, '{3, 8, 3, 5, 1, 4}, '{10, 5, 4, 2, 4, 1}, '{28, 28, 1, 3, 3, 2}
  };

  initial begin
    int phase_end;
    dim_reg = '{6'd28, 6'd28, 6'd1, 6'd3, 6'd3, 6'd2};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_dims(4, 4, 1, 1, 1, 2);
    write_reg(3'd6, 6'h2a);
    write_reg(3'd7, 6'h15);
    dir_tab = '{
      '{mk(FUNC_WEIGHT, 0, 0, 0, 0, 16'h7fff), 0, '0, '0},
      '{mk(FUNC_BIAS, 0, 0, 0, 0, 16'h7fff), 0, '0, '0},
      '{mk(FUNC_INPUT, 0, 0, 0, 0, 16'h7fff), 0, '0, '0},
      '{mk(FUNC_COMPUTE, 0, 0, 0, 0, '0), 1, 16'h7fff, ST_SAT},
      '{mk(FUNC_WEIGHT, 1, 0, 0, 0, 16'h8000), 0, '0, '0},
      '{mk(FUNC_BIAS, 1, 0, 0, 0, 16'h8000), 0, '0, '0},
      '{mk(FUNC_COMPUTE, 1, 0, 0, 0, '0), 1, 16'h8000, ST_SAT},
      '{mk(FUNC_INPUT, 0, 0, 0, 0, 16'h0000), 0, '0, '0},
      '{mk(FUNC_COMPUTE, 0, 0, 0, 0, '0), 1, 16'h7fff, ST_OK},
      '{mk(FUNC_COMPUTE, 1, 0, 0, 0, '0), 1, 16'h8000, ST_OK},
      '{mk(FUNC_COMPUTE, 2, 0, 0, 0, '0), 1, 16'h0000, ST_BAD},
      '{mk(FUNC_COMPUTE, 3, 3, 31, 31, 16'hffff), 1, 16'h0000, ST_BAD},
      '{mk(FUNC_COMPUTE, 0, 0, 4, 0, '0), 1, 16'h0000, ST_BAD},
      '{mk(FUNC_COMPUTE, 0, 0, 0, 31, '0), 1, 16'h0000, ST_BAD},
      '{mk(FUNC_WEIGHT, 0, 0, 7, 0, 16'h1111), 0, '0, '0},
      '{mk(FUNC_WEIGHT, 0, 0, 0, 31, 16'h2222), 0, '0, '0},
      '{mk(FUNC_COMPUTE, 0, 0, 0, 0, '0), 1, 16'h7fff, ST_OK},
      '{mk(FUNC_INPUT, 3, 3, 31, 31, 16'h1234), 0, '0, '0},
      '{mk(FUNC_BIAS, 3, 0, 0, 0, 16'h0100), 0, '0, '0},
      '{mk(FUNC_INPUT, 0, 0, 3, 3, 16'h0180), 0, '0, '0},
      '{mk(FUNC_WEIGHT, 0, 0, 0, 0, 16'h0001), 0, '0, '0},
      '{mk(FUNC_COMPUTE, 0, 0, 3, 3, '0), 0, '0, '0},
      '{mk(FUNC_INPUT, 0, 0, 2, 1, 16'hfe80), 0, '0, '0},
      '{mk(FUNC_COMPUTE, 0, 0, 2, 1, '0), 0, '0, '0}
    };
    foreach (dir_tab[k]) send_item(dir_tab[k].it, dir_tab[k].typed, dir_tab[k].tv, dir_tab[k].ts);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_dims(phase_dims[p][0], phase_dims[p][1], phase_dims[p][2],
               phase_dims[p][3], phase_dims[p][4], phase_dims[p][5]);
      phase_end = in_beats + NUM_ITEMS / NUM_PHASES;
      while (in_beats < phase_end) begin
        idle_phase = p * 3 / NUM_PHASES;
        send_pct = idle_phase == 0 ? 30 : (idle_phase == 1 ? 51 : 0);
        stall_pct = idle_phase == 0 ? 51 : (idle_phase == 1 ? 30 : 0);
        random_step();
      end
      drain();
    end

    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
